>>> hw/rtl/mpts_pkg.sv
// Shared types, constants and helpers for the multi-policy task selector.
// Depends on nothing; every other file of the block refers to it by scoped names.
package mpts_pkg;

    localparam int TIME_W = 48;
    localparam int CNT_W  = 32;
    localparam int PRIO_W = 8;
    localparam int FUNC_W = 3;
    localparam int SLOT_W = 4;
    localparam int STAT_W = 3;
    localparam int POL_W  = 3;
    localparam int KEY_W  = TIME_W + 1;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    // Command codes carried by an input item.
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD      = 3'd0,
        FN_PRIO     = 3'd1,
        FN_PERIOD   = 3'd2,
        FN_PAUSE    = 3'd3,
        FN_RESUME   = 3'd4,
        FN_SELECT   = 3'd5,
        FN_COMPLETE = 3'd6,
        FN_RESTART  = 3'd7
    } t_func;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_BAD_PARAM  = 3'd2,
        ST_BAD_SLOT   = 3'd3,
        ST_NONE_READY = 3'd4
    } t_status;

    // Scheduling policies held in the policy register.
    typedef enum logic [POL_W-1:0] {
        POL_PRIO  = 3'd0,
        POL_RR    = 3'd1,
        POL_EDF   = 3'd2,
        POL_LEAST = 3'd3,
        POL_WAIT  = 3'd4
    } t_policy;

    // Update broadcast to the cells.
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_ADD      = 4'd1,
        OP_PRIO     = 4'd2,
        OP_PERIOD   = 4'd3,
        OP_PAUSE    = 4'd4,
        OP_RESUME   = 4'd5,
        OP_SELECT   = 4'd6,
        OP_COMPLETE = 4'd7,
        OP_RESTART  = 4'd8
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [PRIO_W-1:0]   prio;
        logic [TIME_W-1:0]   period;
        logic                paused;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   jit;
        logic [TIME_W-1:0]   exec;
    } t_cell_cmd;

    // Contents of one cell as seen by the controller.
    typedef struct packed {
        logic [TIME_W-1:0] last;
        logic [TIME_W-1:0] period;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] busy_sum;
        logic [TIME_W-1:0] busy_min;
        logic [TIME_W-1:0] busy_max;
        logic [TIME_W-1:0] jit_sum;
        logic [TIME_W-1:0] jit_peak;
    } t_cell_view;

    // Saturating add on time values.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

>>> hw/rtl/mpts_cmd_if.sv
// Command channel of the task selector: valid/ready handshake and command fields.
// Depends on mpts_pkg for field widths.
interface mpts_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [mpts_pkg::FUNC_W-1:0]  func;
    logic [mpts_pkg::SLOT_W-1:0]  slot;
    logic [mpts_pkg::PRIO_W-1:0]  prio_value;
    logic [mpts_pkg::TIME_W-1:0]  period_us;
    logic                         start_paused;
    logic [mpts_pkg::TIME_W-1:0]  now_us;

    modport source (output valid, func, slot, prio_value, period_us, start_paused, now_us,
                    input ready);
    modport sink (input valid, func, slot, prio_value, period_us, start_paused, now_us,
                  output ready);
endinterface

>>> hw/rtl/mpts_res_if.sv
// Result channel of the task selector: valid/ready handshake and result fields.
// Depends on mpts_pkg for field widths.
interface mpts_res_if;
    logic                         valid;
    logic                         ready;
    logic [mpts_pkg::STAT_W-1:0]  status;
    logic [mpts_pkg::SLOT_W-1:0]  chosen_slot;
    logic [mpts_pkg::CNT_W-1:0]   run_count;
    logic [mpts_pkg::TIME_W-1:0]  busy_sum;
    logic [mpts_pkg::TIME_W-1:0]  busy_min;
    logic [mpts_pkg::TIME_W-1:0]  busy_max;
    logic [mpts_pkg::TIME_W-1:0]  jitter_sum;
    logic [mpts_pkg::TIME_W-1:0]  jitter_peak;
    logic [mpts_pkg::TIME_W-1:0]  global_busy;

    modport source (output valid, status, chosen_slot, run_count, busy_sum, busy_min,
                    busy_max, jitter_sum, jitter_peak, global_busy, input ready);
    modport sink (input valid, status, chosen_slot, run_count, busy_sum, busy_min,
                  busy_max, jitter_sum, jitter_peak, global_busy, output ready);
endinterface

>>> hw/rtl/mpts_cell.sv
// One task slot: holds the task's parameters and statistics, applies updates,
// and refines the selection record that travels down the chain. Depends on mpts_pkg.
module mpts_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  logic                          i_clk,
    input  logic                          i_occupied,
    input  logic                          i_hit,
    input  mpts_pkg::t_cell_cmd           i_cmd,
    input  logic [mpts_pkg::POL_W-1:0]    i_policy,
    input  logic [IDX_W-1:0]              i_rr_start,
    input  logic                          i_found,
    input  logic [IDX_W-1:0]              i_best,
    input  logic [mpts_pkg::KEY_W-1:0]    i_key,
    input  logic                          i_hi_found,
    input  logic [IDX_W-1:0]              i_hi_idx,
    input  logic                          i_any_found,
    input  logic [IDX_W-1:0]              i_any_idx,
    output logic                          o_found,
    output logic [IDX_W-1:0]              o_best,
    output logic [mpts_pkg::KEY_W-1:0]    o_key,
    output logic                          o_hi_found,
    output logic [IDX_W-1:0]              o_hi_idx,
    output logic                          o_any_found,
    output logic [IDX_W-1:0]              o_any_idx,
    output mpts_pkg::t_cell_view          o_view
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [mpts_pkg::PRIO_W-1:0] r_prio;
    logic [mpts_pkg::TIME_W-1:0] r_period;
    logic [mpts_pkg::TIME_W-1:0] r_last;
    logic                        r_paused;
    logic [mpts_pkg::CNT_W-1:0]  r_count;
    logic [mpts_pkg::TIME_W-1:0] r_bsum;
    logic [mpts_pkg::TIME_W-1:0] r_bmin;
    logic [mpts_pkg::TIME_W-1:0] r_bmax;
    logic [mpts_pkg::TIME_W-1:0] r_jsum;
    logic [mpts_pkg::TIME_W-1:0] r_jpeak;

    logic                        started;
    logic [mpts_pkg::TIME_W-1:0] since;
    logic                        ready;
    logic                        elig;
    logic [mpts_pkg::KEY_W-1:0]  key;
    logic [mpts_pkg::KEY_W-1:0]  deadline;
    logic                        take;
    logic                        hi_take;
    logic                        any_take;

    // Readiness and the policy key; every policy but round robin reduces to "strictly larger wins".
    always_comb begin
        started  = i_cmd.now >= r_last;
        since    = i_cmd.now - r_last;
        ready    = i_occupied && !r_paused && started && (since >= r_period);
        deadline = {1'b0, r_last} + {1'b0, r_period};
        elig     = 1'b0;
        key      = '0;
        case (i_policy)
            mpts_pkg::POL_PRIO: begin
                elig = ready;
                key  = mpts_pkg::KEY_W'(r_prio);
            end
            mpts_pkg::POL_EDF: begin
                elig = ready;
                key  = ~deadline;
            end
            mpts_pkg::POL_LEAST: begin
                elig = i_occupied && !r_paused;
                key  = ~(mpts_pkg::KEY_W'(r_count));
            end
            mpts_pkg::POL_WAIT: begin
                elig = i_occupied && !r_paused && started;
                key  = {1'b0, since};
            end
            default: begin
                elig = 1'b0;
                key  = '0;
            end
        endcase
        take     = elig && (!i_found || key > i_key);
        hi_take  = ready && !i_hi_found && (MY_IDX >= i_rr_start);
        any_take = ready && !i_any_found;
    end

    // Selection record handed to the next cell every cycle.
    always_ff @(posedge i_clk) begin
        o_found     <= i_found || take;
        o_best      <= take ? MY_IDX : i_best;
        o_key       <= take ? key : i_key;
        o_hi_found  <= i_hi_found || hi_take;
        o_hi_idx    <= hi_take ? MY_IDX : i_hi_idx;
        o_any_found <= i_any_found || any_take;
        o_any_idx   <= any_take ? MY_IDX : i_any_idx;
    end

    // Task state updates.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            mpts_pkg::OP_ADD: begin
                if (i_hit) begin
                    r_prio   <= i_cmd.prio;
                    r_period <= i_cmd.period;
                    r_last   <= i_cmd.now;
                    r_paused <= i_cmd.paused;
                    r_count  <= '0;
                    r_bsum   <= '0;
                    r_bmin   <= '0;
                    r_bmax   <= '0;
                    r_jsum   <= '0;
                    r_jpeak  <= '0;
                end
            end
            mpts_pkg::OP_PRIO: begin
                if (i_hit) r_prio <= i_cmd.prio;
            end
            mpts_pkg::OP_PERIOD: begin
                if (i_hit) r_period <= i_cmd.period;
            end
            mpts_pkg::OP_PAUSE, mpts_pkg::OP_RESUME: begin
                if (i_hit) begin
                    r_paused <= (i_cmd.op == mpts_pkg::OP_PAUSE);
                    r_jsum   <= '0;
                    r_jpeak  <= '0;
                    r_last   <= i_cmd.now;
                end
            end
            mpts_pkg::OP_SELECT: begin
                if (i_hit) begin
                    r_jsum <= mpts_pkg::sat_add(r_jsum, i_cmd.jit);
                    if (i_cmd.jit > r_jpeak) r_jpeak <= i_cmd.jit;
                end
            end
            mpts_pkg::OP_COMPLETE: begin
                if (i_hit) begin
                    if (r_count == '0 || i_cmd.exec < r_bmin) r_bmin <= i_cmd.exec;
                    if (i_cmd.exec > r_bmax) r_bmax <= i_cmd.exec;
                    if (r_count != mpts_pkg::CNT_MAX) r_count <= r_count + 1'b1;
                    r_bsum <= mpts_pkg::sat_add(r_bsum, i_cmd.exec);
                    r_last <= i_cmd.now;
                end
            end
            mpts_pkg::OP_RESTART: begin
                if (i_occupied) begin
                    r_count  <= '0;
                    r_bsum   <= '0;
                    r_bmin   <= '0;
                    r_bmax   <= '0;
                    r_jsum   <= '0;
                    r_jpeak  <= '0;
                    r_last   <= i_cmd.now;
                    r_paused <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_view = '{last: r_last, period: r_period, count: r_count, busy_sum: r_bsum,
                      busy_min: r_bmin, busy_max: r_bmax, jit_sum: r_jsum,
                      jit_peak: r_jpeak};

endmodule

>>> hw/rtl/multi_policy_task_selector_unit.sv
// Top level of the multi-policy task selector: controller, chain of task cells,
// output register. Depends on mpts_pkg, mpts_cmd_if, mpts_res_if and mpts_cell.
//
//  Port     Dir  Handshake         Carries
//  i_cmd    in   valid/ready       one command item
//  o_res    out  valid/ready       one result item per command
//  i_cfg_*  in   write enable      policy register
//
// A select walks through idle, scan, fetch, calc, exec and report (in the scan step the
// selection record crosses the chain of cells, one cell per cycle); every other command skips the scan.
// Reset is synchronous and active low; it clears the task count, the pending task,
// the global total and the round-robin pointer and sets the policy to round robin.
// A new item is accepted while a finished result waits in the output register; a
// stalled output holds the controller in its report step.
module multi_policy_task_selector_unit #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mpts_pkg::POL_W-1:0]  i_cfg_wdata,
    mpts_cmd_if.sink                    i_cmd,
    mpts_res_if.source                  o_res
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int TOT_W = $clog2(TASK_SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
    localparam logic [TOT_W-1:0] FULL_TOT = TOT_W'(TASK_SLOTS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_FETCH  = 6'b000100,
        S_CALC   = 6'b001000,
        S_EXEC   = 6'b010000,
        S_REPORT = 6'b100000
    } t_state;

    t_state                        r_state;
    logic [IDX_W-1:0]              r_scan_cnt;
    logic [mpts_pkg::POL_W-1:0]    r_policy;
    logic [TOT_W-1:0]              r_total;
    logic [IDX_W-1:0]              r_rr_start;
    logic                          r_pend_valid;
    logic [IDX_W-1:0]              r_pend_slot;
    logic [mpts_pkg::TIME_W-1:0]   r_pend_start;
    logic [mpts_pkg::TIME_W-1:0]   r_global;

    // Latched command.
    logic [mpts_pkg::FUNC_W-1:0]   r_func;
    logic [mpts_pkg::SLOT_W-1:0]   r_slot;
    logic [mpts_pkg::PRIO_W-1:0]   r_prio;
    logic [mpts_pkg::TIME_W-1:0]   r_in_period;
    logic                          r_paused;
    logic [mpts_pkg::TIME_W-1:0]   r_now;

    // Decision and arithmetic results.
    logic [mpts_pkg::STAT_W-1:0]   r_status;
    logic [IDX_W-1:0]              r_tgt;
    logic [IDX_W-1:0]              r_rep;
    logic                          r_rep_ok;
    logic [IDX_W-1:0]              r_chosen;
    logic [mpts_pkg::TIME_W-1:0]   r_f_last;
    logic [mpts_pkg::TIME_W-1:0]   r_f_period;
    logic [mpts_pkg::TIME_W-1:0]   r_jit;
    logic [mpts_pkg::TIME_W-1:0]   r_exec;

    // Output register.
    logic                          r_out_valid;
    logic [mpts_pkg::STAT_W-1:0]   r_o_status;
    logic [mpts_pkg::SLOT_W-1:0]   r_o_chosen;
    mpts_pkg::t_cell_view          r_o_view;
    logic [mpts_pkg::TIME_W-1:0]   r_o_global;

    // Chain wiring between cells.
    logic                          sc_found     [0:TASK_SLOTS];
    logic [IDX_W-1:0]              sc_best      [0:TASK_SLOTS];
    logic [mpts_pkg::KEY_W-1:0]    sc_key       [0:TASK_SLOTS];
    logic                          sc_hi_found  [0:TASK_SLOTS];
    logic [IDX_W-1:0]              sc_hi_idx    [0:TASK_SLOTS];
    logic                          sc_any_found [0:TASK_SLOTS];
    logic [IDX_W-1:0]              sc_any_idx   [0:TASK_SLOTS];
    mpts_pkg::t_cell_view          views        [0:TASK_SLOTS-1];
    logic [TASK_SLOTS-1:0]         occupied;
    logic [TASK_SLOTS-1:0]         hit;

    mpts_pkg::t_cell_cmd           cell_cmd;
    mpts_pkg::t_cell_op            exec_op;
    mpts_pkg::t_cell_view          bus_view;
    logic [IDX_W-1:0]              bus_idx;

    logic                          accept;
    logic                          out_free;
    logic                          slot_ok;
    logic                          win_found;
    logic [IDX_W-1:0]              win_idx;
    logic [mpts_pkg::STAT_W-1:0]   status_c;
    logic [IDX_W-1:0]              tgt_c;
    logic [IDX_W-1:0]              rep_c;
    logic                          rep_ok_c;
    logic [IDX_W-1:0]              chosen_c;
    logic [mpts_pkg::TIME_W-1:0]   d_pos;
    logic [mpts_pkg::TIME_W-1:0]   d_neg;
    logic [mpts_pkg::TIME_W:0]     late_sum;
    logic [mpts_pkg::TIME_W-1:0]   jit_c;
    logic [mpts_pkg::TIME_W-1:0]   exec_c;

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_res.ready;

    // The selection record enters the chain empty.
    assign sc_found[0]     = 1'b0;
    assign sc_best[0]      = '0;
    assign sc_key[0]       = '0;
    assign sc_hi_found[0]  = 1'b0;
    assign sc_hi_idx[0]    = '0;
    assign sc_any_found[0] = 1'b0;
    assign sc_any_idx[0]   = '0;

    // Broadcast command to the cells.
    always_comb begin
        case (r_func)
            mpts_pkg::FN_ADD:      exec_op = mpts_pkg::OP_ADD;
            mpts_pkg::FN_PRIO:     exec_op = mpts_pkg::OP_PRIO;
            mpts_pkg::FN_PERIOD:   exec_op = mpts_pkg::OP_PERIOD;
            mpts_pkg::FN_PAUSE:    exec_op = mpts_pkg::OP_PAUSE;
            mpts_pkg::FN_RESUME:   exec_op = mpts_pkg::OP_RESUME;
            mpts_pkg::FN_SELECT:   exec_op = mpts_pkg::OP_SELECT;
            mpts_pkg::FN_COMPLETE: exec_op = mpts_pkg::OP_COMPLETE;
            mpts_pkg::FN_RESTART:  exec_op = mpts_pkg::OP_RESTART;
            default:               exec_op = mpts_pkg::OP_NONE;
        endcase
        cell_cmd.op     = (r_state == S_EXEC && r_status == mpts_pkg::ST_OK)
                          ? exec_op : mpts_pkg::OP_NONE;
        cell_cmd.prio   = r_prio;
        cell_cmd.period = r_in_period;
        cell_cmd.paused = r_paused;
        cell_cmd.now    = r_now;
        cell_cmd.jit    = r_jit;
        cell_cmd.exec   = r_exec;
    end

    // Row of task cells.
    for (genvar k = 0; k < TASK_SLOTS; k++) begin : g_cell
        assign occupied[k] = TOT_W'(k) < r_total;
        assign hit[k]      = (r_tgt == IDX_W'(k));

        mpts_cell #(
            .IDX_W (IDX_W),
            .IDX   (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_occupied  (occupied[k]),
            .i_hit       (hit[k]),
            .i_cmd       (cell_cmd),
            .i_policy    (r_policy),
            .i_rr_start  (r_rr_start),
            .i_found     (sc_found[k]),
            .i_best      (sc_best[k]),
            .i_key       (sc_key[k]),
            .i_hi_found  (sc_hi_found[k]),
            .i_hi_idx    (sc_hi_idx[k]),
            .i_any_found (sc_any_found[k]),
            .i_any_idx   (sc_any_idx[k]),
            .o_found     (sc_found[k+1]),
            .o_best      (sc_best[k+1]),
            .o_key       (sc_key[k+1]),
            .o_hi_found  (sc_hi_found[k+1]),
            .o_hi_idx    (sc_hi_idx[k+1]),
            .o_any_found (sc_any_found[k+1]),
            .o_any_idx   (sc_any_idx[k+1]),
            .o_view      (views[k])
        );
    end

    // Read one cell onto the view bus.
    assign bus_idx = (r_state == S_FETCH) ? tgt_c : r_rep;

    always_comb begin
        bus_view = '0;
        for (int k = 0; k < TASK_SLOTS; k++) begin
            if (bus_idx == IDX_W'(k)) bus_view = bus_view | views[k];
        end
    end

    // Winner of the scan; round robin prefers the first ready task at or after the pointer.
    always_comb begin
        if (r_policy == mpts_pkg::POL_RR) begin
            win_found = sc_hi_found[TASK_SLOTS] || sc_any_found[TASK_SLOTS];
            win_idx   = sc_hi_found[TASK_SLOTS] ? sc_hi_idx[TASK_SLOTS]
                                                : sc_any_idx[TASK_SLOTS];
        end else begin
            win_found = sc_found[TASK_SLOTS];
            win_idx   = sc_best[TASK_SLOTS];
        end
    end

    // Command decision: status, target slot and reported slot.
    always_comb begin
        slot_ok  = 32'(r_slot) < 32'(r_total);
        status_c = mpts_pkg::ST_OK;
        tgt_c    = IDX_W'(r_slot);
        case (r_func)
            mpts_pkg::FN_ADD: begin
                tgt_c = IDX_W'(r_total);
                if (r_total == FULL_TOT) begin
                    status_c = mpts_pkg::ST_FULL;
                end else if (r_in_period == '0) begin
                    status_c = mpts_pkg::ST_BAD_PARAM;
                end
            end
            mpts_pkg::FN_PRIO, mpts_pkg::FN_PERIOD, mpts_pkg::FN_PAUSE,
            mpts_pkg::FN_RESUME: begin
                if (!slot_ok) status_c = mpts_pkg::ST_BAD_SLOT;
            end
            mpts_pkg::FN_SELECT: begin
                tgt_c = win_idx;
                if (!win_found) status_c = mpts_pkg::ST_NONE_READY;
            end
            mpts_pkg::FN_COMPLETE: begin
                tgt_c = r_pend_slot;
                if (!r_pend_valid || !(TOT_W'(r_pend_slot) < r_total)) begin
                    status_c = mpts_pkg::ST_BAD_PARAM;
                end
            end
            default: begin
                status_c = mpts_pkg::ST_OK;
            end
        endcase
        if (status_c == mpts_pkg::ST_OK &&
            (r_func == mpts_pkg::FN_ADD || r_func == mpts_pkg::FN_SELECT ||
             r_func == mpts_pkg::FN_COMPLETE)) begin
            rep_c    = tgt_c;
            rep_ok_c = 1'b1;
        end else begin
            rep_c    = IDX_W'(r_slot);
            rep_ok_c = slot_ok;
        end
        if (status_c == mpts_pkg::ST_OK &&
            (r_func == mpts_pkg::FN_ADD || r_func == mpts_pkg::FN_SELECT)) begin
            chosen_c = tgt_c;
        end else begin
            chosen_c = '0;
        end
    end

    // Jitter of a selected task and execution time of a completed one.
    always_comb begin
        d_pos    = r_now - r_f_last;
        d_neg    = r_f_last - r_now;
        late_sum = {1'b0, d_neg} + {1'b0, r_f_period};
        if (r_now >= r_f_last) begin
            jit_c = (d_pos >= r_f_period) ? d_pos - r_f_period : r_f_period - d_pos;
        end else begin
            jit_c = late_sum[mpts_pkg::TIME_W] ? mpts_pkg::TIME_MAX
                                               : late_sum[mpts_pkg::TIME_W-1:0];
        end
        exec_c = (r_now >= r_pend_start) ? r_now - r_pend_start : '0;
    end

    // Controller.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_scan_cnt   <= '0;
            r_policy     <= mpts_pkg::POL_RR;
            r_total      <= '0;
            r_rr_start   <= '0;
            r_pend_valid <= 1'b0;
            r_pend_slot  <= '0;
            r_pend_start <= '0;
            r_global     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_policy <= i_cfg_wdata;
            // The report step sets the output valid itself when it has room.
            if (r_out_valid && o_res.ready && r_state != S_REPORT) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_scan_cnt <= '0;
                        r_state    <= (i_cmd.func == mpts_pkg::FN_SELECT) ? S_SCAN
                                                                          : S_FETCH;
                    end
                end
                S_SCAN: begin
                    r_scan_cnt <= r_scan_cnt + 1'b1;
                    if (r_scan_cnt == LAST_IDX) r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (r_status == mpts_pkg::ST_OK) begin
                        case (r_func)
                            mpts_pkg::FN_ADD: begin
                                r_total <= r_total + 1'b1;
                            end
                            mpts_pkg::FN_SELECT: begin
                                r_pend_valid <= 1'b1;
                                r_pend_slot  <= r_tgt;
                                r_pend_start <= r_now;
                                if (r_policy == mpts_pkg::POL_RR) begin
                                    r_rr_start <= (r_tgt == LAST_IDX) ? '0 : r_tgt + 1'b1;
                                end
                            end
                            mpts_pkg::FN_COMPLETE: begin
                                r_global     <= mpts_pkg::sat_add(r_global, r_exec);
                                r_pend_valid <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func      <= i_cmd.func;
            r_slot      <= i_cmd.slot;
            r_prio      <= i_cmd.prio_value;
            r_in_period <= i_cmd.period_us;
            r_paused    <= i_cmd.start_paused;
            r_now       <= i_cmd.now_us;
        end
        if (r_state == S_FETCH) begin
            r_status   <= status_c;
            r_tgt      <= tgt_c;
            r_rep      <= rep_c;
            r_rep_ok   <= rep_ok_c;
            r_chosen   <= chosen_c;
            r_f_last   <= bus_view.last;
            r_f_period <= bus_view.period;
        end
        if (r_state == S_CALC) begin
            r_jit  <= jit_c;
            r_exec <= exec_c;
        end
        if (r_state == S_REPORT && out_free) begin
            r_o_status <= r_status;
            r_o_chosen <= mpts_pkg::SLOT_W'(r_chosen);
            r_o_view   <= r_rep_ok ? bus_view : '0;
            r_o_global <= r_global;
        end
    end

    // Result channel.
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_o_status;
    assign o_res.chosen_slot = r_o_chosen;
    assign o_res.run_count   = r_o_view.count;
    assign o_res.busy_sum    = r_o_view.busy_sum;
    assign o_res.busy_min    = r_o_view.busy_min;
    assign o_res.busy_max    = r_o_view.busy_max;
    assign o_res.jitter_sum  = r_o_view.jit_sum;
    assign o_res.jitter_peak = r_o_view.jit_peak;
    assign o_res.global_busy = r_o_global;

    // A result appears only out of the report step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_REPORT))
        else $error("result raised outside the report step");

    // A pending task always names an occupied slot.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (TOT_W'(r_pend_slot) < r_total))
        else $error("pending task outside the table");

    // The task count never exceeds the table.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= FULL_TOT)
        else $error("task count beyond table size");

    // The report step never overwrites a result that is still waiting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPORT && r_out_valid && !o_res.ready) |=> (r_state == S_REPORT))
        else $error("report left while output stalled");

endmodule

>>> tb/sv/mpts_tb_if.sv
// Testbench-side notes: the command and result channels come from the RTL interfaces.
// This file holds the channel-level item types used by the stimulus and the checker.
// Depends on mpts_pkg.
package mpts_tb_pkg;
    import mpts_pkg::*;

    // One command item as driven onto the command channel.
    typedef struct packed {
        t_func              func;
        logic [SLOT_W-1:0]  slot;
        logic [PRIO_W-1:0]  prio;
        logic [TIME_W-1:0]  period;
        logic               paused;
        logic [TIME_W-1:0]  now;
    } t_cmd_item;

    // One result item as seen on the result channel.
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  chosen;
        logic [CNT_W-1:0]   count;
        logic [TIME_W-1:0]  bsum;
        logic [TIME_W-1:0]  bmin;
        logic [TIME_W-1:0]  bmax;
        logic [TIME_W-1:0]  jsum;
        logic [TIME_W-1:0]  jpeak;
        logic [TIME_W-1:0]  gbusy;
    } t_res_item;
endpackage

>>> tb/sv/mpts_checker.sv
// Checker for the task selector: watches the command, result and policy ports,
// keeps its own task table, predicts each result and compares it field by field.
// Depends on mpts_pkg, mpts_tb_pkg and the channel interfaces.
module mpts_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mpts_pkg::POL_W-1:0]  i_cfg_wdata,
    mpts_cmd_if                         cmd,
    mpts_res_if                         res,
    output int                          o_fail_count,
    output int                          o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import mpts_pkg::*;
    import mpts_tb_pkg::*;

    localparam int SLOTS = 16;

    logic [PRIO_W-1:0] m_prio   [SLOTS];
    logic [TIME_W-1:0] m_period [SLOTS];
    logic [TIME_W-1:0] m_last   [SLOTS];
    logic              m_paused [SLOTS];
    logic [CNT_W-1:0]  m_count  [SLOTS];
    logic [TIME_W-1:0] m_bsum   [SLOTS];
    logic [TIME_W-1:0] m_bmin   [SLOTS];
    logic [TIME_W-1:0] m_bmax   [SLOTS];
    logic [TIME_W-1:0] m_jsum   [SLOTS];
    logic [TIME_W-1:0] m_jpeak  [SLOTS];
    int                m_total;
    int                m_rr;
    bit                m_pend;
    int                m_pend_slot;
    logic [TIME_W-1:0] m_pend_start;
    logic [TIME_W-1:0] m_gbusy;
    logic [POL_W-1:0]  m_policy;

    t_res_item expected_results[$];
    int        fails;

    assign o_fail_count = fails;

    function automatic logic [TIME_W-1:0] sat48(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic bit task_due(int i, logic [TIME_W-1:0] now);
        if (m_paused[i] || now < m_last[i]) return 0;
        return (now - m_last[i]) >= m_period[i];
    endfunction

    // Chooses a slot under the current policy, or -1 when none qualifies.
    function automatic int choose_task(logic [TIME_W-1:0] now);
        int best;
        logic [TIME_W:0] key;
        logic [TIME_W:0] dl;
        int idx;
        best = -1;
        key = '0;
        case (m_policy)
            POL_PRIO: for (int i = 0; i < m_total; i++)
                if (task_due(i, now) && (best < 0 || m_prio[i] > key)) begin
                    best = i; key = m_prio[i];
                end
            POL_RR: for (int i = 0; i < m_total; i++) begin
                idx = (m_rr + i) % m_total;
                if (task_due(idx, now)) begin
                    m_rr = (idx + 1) % SLOTS;
                    return idx;
                end
            end
            POL_EDF: for (int i = 0; i < m_total; i++) begin
                dl = {1'b0, m_last[i]} + {1'b0, m_period[i]};
                if (task_due(i, now) && (best < 0 || dl < key)) begin
                    best = i; key = dl;
                end
            end
            POL_LEAST: for (int i = 0; i < m_total; i++)
                if (!m_paused[i] && (best < 0 || m_count[i] < key)) begin
                    best = i; key = m_count[i];
                end
            POL_WAIT: for (int i = 0; i < m_total; i++)
                if (!m_paused[i] && now >= m_last[i]
                        && (best < 0 || (now - m_last[i]) > key)) begin
                    best = i; key = now - m_last[i];
                end
            default: ;
        endcase
        return best;
    endfunction

    function automatic void clear_stats(int i);
        m_count[i] = '0; m_bsum[i] = '0; m_bmin[i] = '0;
        m_bmax[i] = '0; m_jsum[i] = '0; m_jpeak[i] = '0;
    endfunction

    // Applies one command to the model table and returns the result it produces.
    function automatic t_res_item apply_command(t_cmd_item c);
        t_res_item r;
        int rep;
        int sel;
        logic [TIME_W:0] jit;
        logic [TIME_W-1:0] e;
        r = '0;
        rep = c.slot;
        case (c.func)
            FN_ADD: begin
                if (m_total >= SLOTS) r.status = ST_FULL;
                else if (c.period == 0) r.status = ST_BAD_PARAM;
                else begin
                    m_prio[m_total] = c.prio; m_period[m_total] = c.period;
                    m_last[m_total] = c.now; m_paused[m_total] = c.paused;
                    clear_stats(m_total);
                    r.chosen = SLOT_W'(m_total); rep = m_total;
                    m_total++;
                end
            end
            FN_PRIO, FN_PERIOD, FN_PAUSE, FN_RESUME: begin
                if (c.slot >= m_total) r.status = ST_BAD_SLOT;
                else if (c.func == FN_PRIO) m_prio[c.slot] = c.prio;
                else if (c.func == FN_PERIOD) m_period[c.slot] = c.period;
                else begin
                    m_paused[c.slot] = (c.func == FN_PAUSE);
                    m_jsum[c.slot] = '0; m_jpeak[c.slot] = '0;
                    m_last[c.slot] = c.now;
                end
            end
            FN_SELECT: begin
                sel = choose_task(c.now);
                if (sel < 0) r.status = ST_NONE_READY;
                else begin
                    if (c.now >= m_last[sel]) begin
                        e = c.now - m_last[sel];
                        jit = (e >= m_period[sel]) ? e - m_period[sel] : m_period[sel] - e;
                    end else
                        jit = {1'b0, m_last[sel] - c.now} + {1'b0, m_period[sel]};
                    if (jit[TIME_W]) jit = {1'b0, TIME_MAX};
                    m_jsum[sel] = sat48(m_jsum[sel], jit[TIME_W-1:0]);
                    if (jit[TIME_W-1:0] > m_jpeak[sel]) m_jpeak[sel] = jit[TIME_W-1:0];
                    m_pend = 1; m_pend_slot = sel; m_pend_start = c.now;
                    r.chosen = SLOT_W'(sel); rep = sel;
                end
            end
            FN_COMPLETE: begin
                if (!m_pend || m_pend_slot >= m_total) r.status = ST_BAD_PARAM;
                else begin
                    e = (c.now >= m_pend_start) ? c.now - m_pend_start : '0;
                    rep = m_pend_slot;
                    if (m_count[rep] == 0 || e < m_bmin[rep]) m_bmin[rep] = e;
                    if (e > m_bmax[rep]) m_bmax[rep] = e;
                    if (m_count[rep] != CNT_MAX) m_count[rep]++;
                    m_bsum[rep] = sat48(m_bsum[rep], e);
                    m_last[rep] = c.now;
                    m_gbusy = sat48(m_gbusy, e);
                    m_pend = 0;
                end
            end
            default: for (int i = 0; i < m_total; i++) begin
                clear_stats(i); m_last[i] = c.now; m_paused[i] = 0;
            end
        endcase
        if (rep < m_total) begin
            r.count = m_count[rep]; r.bsum = m_bsum[rep];
            r.bmin = (m_count[rep] != 0) ? m_bmin[rep] : '0;
            r.bmax = m_bmax[rep]; r.jsum = m_jsum[rep]; r.jpeak = m_jpeak[rep];
        end
        r.gbusy = m_gbusy;
        return r;
    endfunction

    // Track commands, policy writes and results at each rising edge.
    always @(posedge i_clk) begin
        t_cmd_item c;
        t_res_item got;
        t_res_item want;
        if (!i_rst_n) begin
            m_total = 0; m_rr = 0; m_pend = 0; m_pend_slot = 0;
            m_pend_start = '0; m_gbusy = '0; m_policy = POL_RR;
            expected_results.delete();
            fails = 0;
        end else begin
            if (res.valid && res.ready) begin
                got = '{res.status, res.chosen_slot, res.run_count, res.busy_sum,
                        res.busy_min, res.busy_max, res.jitter_sum, res.jitter_peak,
                        res.global_busy};
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("ERROR: result item with none expected");
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                                     want, got);
                    end
                end
            end
            if (cmd.valid && cmd.ready) begin
                c.func = t_func'(cmd.func); c.slot = cmd.slot; c.prio = cmd.prio_value;
                c.period = cmd.period_us; c.paused = cmd.start_paused; c.now = cmd.now_us;
                expected_results.push_back(apply_command(c));
            end
            if (i_cfg_we) m_policy = i_cfg_wdata;
        end
        o_waiting = expected_results.size();
    end
endmodule

>>> tb/sv/multi_policy_task_selector_unit_test.sv
// Top of the task selector testbench: clock, reset, command stimulus under all
// policies, result back-pressure and the verdict. Depends on mpts_checker.
module multi_policy_task_selector_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mpts_pkg::*;

    logic              clk = 0;
    logic              rst_n = 0;
    logic              cfg_we = 0;
    logic [POL_W-1:0]  cfg_wdata = '0;
    int                fail_count;
    int                waiting;
    bit                hold_off = 0;
    bit                rand_stall = 1;
    logic [TIME_W-1:0] clock_us = 1000;

    mpts_cmd_if cmd ();
    mpts_res_if res ();

    multi_policy_task_selector_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_cmd(cmd), .o_res(res)
    );

    mpts_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .cmd(cmd), .res(res), .o_fail_count(fail_count), .o_waiting(waiting)
    );

    always #5 clk = ~clk;

    initial begin
        cmd.valid = 0; cmd.func = '0; cmd.slot = '0; cmd.prio_value = '0;
        cmd.period_us = '0; cmd.start_paused = 0; cmd.now_us = '0;
        res.ready = 0;
    end

    // Result side: random stalls per item, or a long hold-off when asked.
    initial begin
        int gap;
        @(posedge clk iff rst_n);
        forever begin
            gap = (rand_stall && $urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
            while (hold_off || gap > 0) begin
                res.ready <= 0;
                @(posedge clk);
                if (gap > 0) gap--;
            end
            res.ready <= 1;
            @(posedge clk iff res.valid);
        end
    end

    // Sends one command item and waits for it to be accepted.
    task automatic send_cmd(t_func f, logic [SLOT_W-1:0] s, logic [PRIO_W-1:0] p,
                            logic [TIME_W-1:0] per, logic sp, logic [TIME_W-1:0] now,
                            bit idle);
        int gap;
        gap = (idle && $urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
        repeat (gap) begin
            cmd.valid <= 0;
            @(posedge clk);
        end
        cmd.valid <= 1; cmd.func <= f; cmd.slot <= s; cmd.prio_value <= p;
        cmd.period_us <= per; cmd.start_paused <= sp; cmd.now_us <= now;
        @(posedge clk iff cmd.ready);
    endtask

    task automatic drain();
        cmd.valid <= 0;
        @(posedge clk iff waiting == 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_policy(logic [POL_W-1:0] v);
        cfg_we <= 1; cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [TIME_W-1:0] rand_time48();
        return {$urandom(), $urandom()};
    endfunction

    // One random command biased toward a running schedule with advancing time.
    task automatic random_cmd();
        int r;
        t_func f;
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] now;
        r = $urandom_range(0, 99);
        if (r < 8) f = FN_ADD;
        else if (r < 14) f = FN_PRIO;
        else if (r < 20) f = FN_PERIOD;
        else if (r < 25) f = FN_PAUSE;
        else if (r < 32) f = FN_RESUME;
        else if (r < 62) f = FN_SELECT;
        else if (r < 92) f = FN_COMPLETE;
        else f = FN_RESTART;
        per = ($urandom_range(0, 9) == 0) ? rand_time48()
                                          : TIME_W'($urandom_range(0, 400));
        clock_us += $urandom_range(0, 150);
        now = clock_us;
        if ($urandom_range(0, 29) == 0) now = rand_time48();
        else if ($urandom_range(0, 19) == 0) now = clock_us - $urandom_range(0, 500);
        send_cmd(f, $urandom_range(0, 15), $urandom_range(0, 255), per,
                 $urandom_range(0, 1), now, 1);
    endtask

    // Directed checks, then random phases under every policy, with one pressure phase.
    initial begin
        rand_stall = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_cmd(FN_COMPLETE, 0, 0, 0, 0, 10, 0);
        send_cmd(FN_SELECT, 0, 0, 0, 0, 10, 0);
        send_cmd(FN_PRIO, 15, 8'hFF, 0, 0, 10, 0);
        send_cmd(FN_ADD, 0, 8'h00, 0, 0, 10, 0);
        send_cmd(FN_ADD, 0, 8'hFF, TIME_MAX, 0, 0, 0);
        send_cmd(FN_ADD, 0, 8'h10, 48'd1, 1, 20, 0);
        send_cmd(FN_ADD, 0, 8'h80, 48'd5, 0, 20, 0);
        send_cmd(FN_SELECT, 0, 0, 0, 0, TIME_MAX, 0);
        send_cmd(FN_SELECT, 0, 0, 0, 0, 30, 0);
        send_cmd(FN_COMPLETE, 0, 0, 0, 0, 5, 0);
        send_cmd(FN_RESUME, 1, 0, 0, 0, 40, 0);
        send_cmd(FN_PERIOD, 1, 0, 48'd0, 0, 0, 0);
        send_cmd(FN_SELECT, 0, 0, 0, 0, 45, 0);
        send_cmd(FN_COMPLETE, 0, 0, 0, 0, TIME_MAX, 0);
        send_cmd(FN_PAUSE, 2, 0, 0, 0, 50, 0);
        send_cmd(FN_RESTART, 0, 0, 0, 0, 60, 0);
        send_cmd(FN_PRIO, 2, 8'hAA, 0, 0, 60, 0);
        drain();
        for (int k = 0; k < 13; k++)
            send_cmd(FN_ADD, 0, $urandom_range(0, 255), 48'd3, 0, 70, 0);
        drain();
        write_policy(3'd7);
        send_cmd(FN_SELECT, 0, 0, 0, 0, 100, 0);
        drain();

        // Random phases over every policy, the extremes and an invalid one included.
        for (int ph = 0; ph < 8; ph++) begin
            logic [POL_W-1:0] pol;
            pol = (ph < 5) ? POL_W'(ph) : (ph == 5 ? 3'd7 : POL_W'($urandom_range(0, 4)));
            write_policy(pol);
            if (ph == 1 || ph == 4) begin
                clock_us = 1000;
                send_cmd(FN_RESTART, 0, 0, 0, 0, clock_us, 0);
            end
            if (ph == 2) begin
                // Hold the result side off while commands keep coming.
                hold_off = 1;
                fork
                    begin repeat (400) @(posedge clk); hold_off = 0; end
                    repeat (40) random_cmd();
                join
            end
            repeat (110) random_cmd();
            drain();
        end

        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

>>> multi_policy_task_selector_unit.f
hw/rtl/mpts_pkg.sv
hw/rtl/mpts_cmd_if.sv
hw/rtl/mpts_res_if.sv
hw/rtl/mpts_cell.sv
hw/rtl/multi_policy_task_selector_unit.sv
tb/sv/mpts_tb_if.sv
tb/sv/mpts_checker.sv
tb/sv/multi_policy_task_selector_unit_test.sv
